### rtl/core/lrf_pkg.sv
// Shared types and fixed constants of the linear regression fit block.
`timescale 1ns / 1ps
`default_nettype none

package lrf_pkg;

    // Sample width, fixed by the Q8.8 sample ports.
    localparam int SAMPLE_BITS = 16;
    // Result word and sample count port widths.
    localparam int OUT_W       = 32;
    localparam int CNT_OUT_W   = 11;

    // Scaling of the numerators before division: Q16.16 slope from raw sums,
    // Q16.16 intercept from sums that already carry Q8.8 in y.
    localparam int SLOPE_SHIFT = 16;
    localparam int ICPT_SHIFT  = 8;

    // Quotient register with a sticky ceiling well above the 32-bit range.
    localparam int              Q_W       = 34;
    localparam logic [Q_W-1:0]  Q_CAP     = 34'h2_0000_0000;
    localparam logic [Q_W-1:0]  Q_POS_MAX = 34'h0_7FFF_FFFF;
    localparam logic [Q_W-1:0]  Q_NEG_MAX = 34'h0_8000_0000;

    localparam logic [OUT_W-1:0] RES_POS_SAT = 32'h7FFF_FFFF;
    localparam logic [OUT_W-1:0] RES_NEG_SAT = 32'h8000_0000;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_DEGEN = 2'd1,
        ST_SAT   = 2'd2
    } t_status;

    // Status from the sample accumulator to the fit sequencer.
    typedef struct packed {
        logic last_done;   // final sample of the set has been summed
        logic ovf;         // a sample of the set was dropped at capacity
    } t_acc_stat;

endpackage

`default_nettype wire

### rtl/core/lrf_accum.sv
// Sample front end: product stage and running sums, count and x range.
`timescale 1ns / 1ps
`default_nettype none

module lrf_accum
    import lrf_pkg::*;
#(
    parameter int MAX_SAMPLES = 1024,
    localparam int SB    = SAMPLE_BITS,
    localparam int CNT_W = $clog2(MAX_SAMPLES + 1),
    localparam int AX_W  = SB + CNT_W,
    localparam int AXX_W = 2 * SB + CNT_W
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_push,
    input  wire logic signed [SB-1:0]    i_x,
    input  wire logic signed [SB-1:0]    i_y,
    input  wire logic                    i_last,
    input  wire logic                    i_clear,
    output logic signed [AX_W-1:0]       o_sum_x,
    output logic signed [AX_W-1:0]       o_sum_y,
    output logic signed [AXX_W-1:0]      o_sum_xx,
    output logic signed [AXX_W-1:0]      o_sum_xy,
    output logic [CNT_W-1:0]             o_count,
    output logic signed [SB-1:0]         o_min_x,
    output logic signed [SB-1:0]         o_max_x,
    output t_acc_stat                    o_stat
);

    localparam logic [SB-1:0] MIN_INIT = {1'b0, {(SB - 1){1'b1}}};
    localparam logic [SB-1:0] MAX_INIT = {1'b1, {(SB - 1){1'b0}}};

    logic signed [2*SB-1:0] x_w;
    logic signed [2*SB-1:0] y_w;

    logic                   r_s1_valid;
    logic                   r_s1_last;
    logic signed [SB-1:0]   r_s1_x;
    logic signed [2*SB-1:0] r_s1_xx;
    logic signed [2*SB-1:0] r_s1_xy;
    logic signed [SB-1:0]   r_s1_y;

    logic signed [AX_W-1:0]  r_sum_x;
    logic signed [AX_W-1:0]  r_sum_y;
    logic signed [AXX_W-1:0] r_sum_xx;
    logic signed [AXX_W-1:0] r_sum_xy;
    logic [CNT_W-1:0]        r_count;
    logic signed [SB-1:0]    r_min_x;
    logic signed [SB-1:0]    r_max_x;
    logic                    r_ovf;
    logic                    r_last_done;

    logic room;

    assign x_w  = {{SB{i_x[SB-1]}}, i_x};
    assign y_w  = {{SB{i_y[SB-1]}}, i_y};
    assign room = (r_count < CNT_W'(MAX_SAMPLES));

    // Stage 1: register the sample and both products.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_s1_x    <= i_x;
            r_s1_y    <= i_y;
            r_s1_xx   <= x_w * x_w;
            r_s1_xy   <= x_w * y_w;
            r_s1_last <= i_last;
        end
    end

    // Stage 2: fold the beat into the sums, or drop it once full.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_last_done <= 1'b0;
        end else begin
            r_s1_valid  <= i_push;
            r_last_done <= r_s1_valid && r_s1_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_sum_x  <= '0;
            r_sum_y  <= '0;
            r_sum_xx <= '0;
            r_sum_xy <= '0;
            r_count  <= '0;
            r_min_x  <= MIN_INIT;
            r_max_x  <= MAX_INIT;
            r_ovf    <= 1'b0;
        end else if (r_s1_valid) begin
            if (room) begin
                r_sum_x  <= r_sum_x + {{(AX_W - SB){r_s1_x[SB-1]}}, r_s1_x};
                r_sum_y  <= r_sum_y + {{(AX_W - SB){r_s1_y[SB-1]}}, r_s1_y};
                r_sum_xx <= r_sum_xx + {{(AXX_W - 2*SB){r_s1_xx[2*SB-1]}}, r_s1_xx};
                r_sum_xy <= r_sum_xy + {{(AXX_W - 2*SB){r_s1_xy[2*SB-1]}}, r_s1_xy};
                r_count  <= r_count + CNT_W'(1);
                if (r_s1_x < r_min_x) begin
                    r_min_x <= r_s1_x;
                end
                if (r_s1_x > r_max_x) begin
                    r_max_x <= r_s1_x;
                end
            end else begin
                r_ovf <= 1'b1;
            end
        end
    end

    assign o_sum_x          = r_sum_x;
    assign o_sum_y          = r_sum_y;
    assign o_sum_xx         = r_sum_xx;
    assign o_sum_xy         = r_sum_xy;
    assign o_count          = r_count;
    assign o_min_x          = r_min_x;
    assign o_max_x          = r_max_x;
    assign o_stat.last_done = r_last_done;
    assign o_stat.ovf       = r_ovf;

endmodule

`default_nettype wire

### rtl/core/linear_regression_fit.sv
// Top level: streaming least-squares line fit with one shared add/subtract unit.
// Non-final samples: one beat per cycle while the sequencer is idle; they never stall the input.
// Final sample to result: the shift-add multiplier (AX_W steps per product) and the
// restoring divider (NUM_W steps per quotient) do the work; a degenerate set skips both divisions.
// Reset: synchronous, active low; clears sums, count, x range, sequencer and output valid.
`timescale 1ns / 1ps
`default_nettype none

module linear_regression_fit
    import lrf_pkg::*;
#(
    parameter int MAX_SAMPLES = 1024
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // sample channel
    input  wire logic                    i_valid,
    output logic                         o_stall,
    input  wire logic signed [15:0]      i_x_value,
    input  wire logic signed [15:0]      i_y_value,
    input  wire logic                    i_last,
    // result channel
    output logic                         o_valid,
    input  wire logic                    i_stall,
    output logic signed [31:0]           o_slope,
    output logic signed [31:0]           o_intercept,
    output logic signed [15:0]           o_min_x,
    output logic signed [15:0]           o_max_x,
    output logic [10:0]                  o_sample_count,
    output logic [1:0]                   o_status
);

    // Sizes of the running sums and of the shared datapath.
    localparam int SB     = SAMPLE_BITS;
    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int AX_W   = SB + CNT_W;          // sum of x, sum of y
    localparam int AXX_W  = 2 * SB + CNT_W;      // sum of x*x, sum of x*y
    localparam int PW     = AXX_W + AX_W + 1;    // difference of two products
    localparam int AW     = PW + 1;              // shared adder width
    localparam int MW     = AX_W;                // multiplier operand bits
    localparam int NUM_W  = PW + SLOPE_SHIFT;    // scaled numerator magnitude
    localparam int STEP_W = $clog2(NUM_W);

    // Product schedule. Even entries start a fresh sum, odd ones subtract.
    localparam logic [2:0] P_N_SXX  = 3'd0;   // + n * Sxx
    localparam logic [2:0] P_SX_SX  = 3'd1;   // - Sx * Sx      -> denominator
    localparam logic [2:0] P_N_SXY  = 3'd2;   // + n * Sxy
    localparam logic [2:0] P_SX_SY  = 3'd3;   // - Sx * Sy      -> slope numerator
    localparam logic [2:0] P_SY_SXX = 3'd4;   // + Sy * Sxx
    localparam logic [2:0] P_SX_SXY = 3'd5;   // - Sx * Sxy     -> intercept numerator

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_DRAIN = 10'b00_0000_0010,
        S_LOAD  = 10'b00_0000_0100,
        S_MUL   = 10'b00_0000_1000,
        S_DCHK  = 10'b00_0001_0000,
        S_NEG   = 10'b00_0010_0000,
        S_DIV   = 10'b00_0100_0000,
        S_ROUND = 10'b00_1000_0000,
        S_CLAMP = 10'b01_0000_0000,
        S_EMIT  = 10'b10_0000_0000
    } t_state;

    // ---------------------------------------------------------------
    // Sample accumulator
    // ---------------------------------------------------------------
    t_state                  r_state;
    logic                    in_beat;
    logic                    emit_fire;
    logic signed [AX_W-1:0]  sum_x;
    logic signed [AX_W-1:0]  sum_y;
    logic signed [AXX_W-1:0] sum_xx;
    logic signed [AXX_W-1:0] sum_xy;
    logic [CNT_W-1:0]        acc_count;
    logic signed [SB-1:0]    acc_min_x;
    logic signed [SB-1:0]    acc_max_x;
    t_acc_stat               acc_stat;

    // Take samples only while the sequencer rests; a final sample locks the
    // input until its result has been placed in the output register.
    assign o_stall = (r_state != S_IDLE);
    assign in_beat = i_valid && !o_stall;

    lrf_accum #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_accum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (in_beat),
        .i_x      (i_x_value),
        .i_y      (i_y_value),
        .i_last   (i_last),
        .i_clear  (emit_fire),
        .o_sum_x  (sum_x),
        .o_sum_y  (sum_y),
        .o_sum_xx (sum_xx),
        .o_sum_xy (sum_xy),
        .o_count  (acc_count),
        .o_min_x  (acc_min_x),
        .o_max_x  (acc_max_x),
        .o_stat   (acc_stat)
    );

    // ---------------------------------------------------------------
    // Sequencer and datapath registers
    // ---------------------------------------------------------------
    logic [2:0]          r_prod;
    logic [STEP_W-1:0]   r_step;
    logic                r_phase;      // 0 slope pass, 1 intercept pass
    logic                r_neg;        // numerator sign of the current pass
    logic                r_sat;
    logic                r_degen;
    logic                r_out_valid;

    logic [AW-1:0]       r_acc;        // product sum, then numerator
    logic [AW-1:0]       r_mcand;      // multiplicand, shifted up each step
    logic [MW-1:0]       r_mplier;     // multiplier, shifted down each step
    logic [PW-1:0]       r_den;
    logic [NUM_W-1:0]    r_num;        // numerator bits, MSB first
    logic [PW-1:0]       r_rem;
    logic [Q_W-1:0]      r_q;
    logic [OUT_W-1:0]    r_slope;
    logic [OUT_W-1:0]    r_icpt;

    logic [OUT_W-1:0]    r_out_slope;
    logic [OUT_W-1:0]    r_out_icpt;
    logic [SB-1:0]       r_out_min_x;
    logic [SB-1:0]       r_out_max_x;
    logic [CNT_OUT_W-1:0] r_out_count;
    t_status             r_out_status;

    // ---------------------------------------------------------------
    // Shared add/subtract unit. Carry out on a subtract means a >= b.
    // ---------------------------------------------------------------
    logic [AW-1:0] alu_a;
    logic [AW-1:0] alu_b;
    logic          alu_sub;
    logic [AW:0]   alu_sum;
    logic [AW-1:0] alu_res;
    logic          alu_ge;

    logic          mul_msb;
    logic          prod_neg;
    logic [AW-1:0] div_trial;

    // The top multiplier bit carries negative weight; a product that is
    // subtracted flips the sense of every partial add.
    assign mul_msb   = (r_step == STEP_W'(MW - 1));
    assign prod_neg  = (r_prod == P_SX_SX) || (r_prod == P_SX_SY) || (r_prod == P_SX_SXY);
    assign div_trial = {r_rem, r_num[NUM_W-1]};

    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        unique case (r_state)
            S_MUL: begin
                alu_a   = r_acc;
                alu_b   = r_mcand;
                alu_sub = mul_msb ^ prod_neg;
            end
            S_NEG: begin
                alu_b   = r_acc;
                alu_sub = 1'b1;
            end
            S_DIV: begin
                alu_a   = div_trial;
                alu_b   = {1'b0, r_den};
                alu_sub = 1'b1;
            end
            S_ROUND: begin
                alu_a   = {r_rem, 1'b0};
                alu_b   = {1'b0, r_den};
                alu_sub = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign alu_sum = {1'b0, alu_a} + {1'b0, alu_b ^ {AW{alu_sub}}} + {{AW{1'b0}}, alu_sub};
    assign alu_res = alu_sum[AW-1:0];
    assign alu_ge  = alu_sum[AW];

    // ---------------------------------------------------------------
    // Helpers for numerator load, quotient step and final clamp
    // ---------------------------------------------------------------
    logic [AW-1:0]    mag;
    logic [Q_W:0]     q_shift;
    logic [Q_W-1:0]   q_step;
    logic [OUT_W-1:0] q_low;
    logic [OUT_W-1:0] clamp_val;
    logic             clamp_sat;

    // In the negate state the adder yields 0 - numerator.
    assign mag = r_acc[AW-1] ? alu_res : r_acc;

    // Hold the quotient at its ceiling once it runs past; the exact value
    // beyond that only matters as "saturated".
    assign q_shift = {r_q, alu_ge};
    assign q_step  = (q_shift > {1'b0, Q_CAP}) ? Q_CAP : q_shift[Q_W-1:0];

    assign q_low = r_q[OUT_W-1:0];

    always_comb begin
        clamp_sat = 1'b0;
        clamp_val = q_low;
        if (!r_neg) begin
            if (r_q > Q_POS_MAX) begin
                clamp_sat = 1'b1;
                clamp_val = RES_POS_SAT;
            end
        end else begin
            if (r_q > Q_NEG_MAX) begin
                clamp_sat = 1'b1;
                clamp_val = RES_NEG_SAT;
            end else begin
                clamp_val = ~q_low + OUT_W'(1);
            end
        end
    end

    // Result lands once the output register is free or being drained.
    assign emit_fire = (r_state == S_EMIT) && (!r_out_valid || !i_stall);

    // ---------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_prod      <= P_N_SXX;
            r_step      <= '0;
            r_phase     <= 1'b0;
            r_neg       <= 1'b0;
            r_sat       <= 1'b0;
            r_degen     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_beat && i_last) begin
                        r_state <= S_DRAIN;
                    end
                end
                // Wait for the final beat to reach the sums.
                S_DRAIN: begin
                    if (acc_stat.last_done) begin
                        r_prod  <= P_N_SXX;
                        r_phase <= 1'b0;
                        r_sat   <= 1'b0;
                        r_degen <= 1'b0;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_step  <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    if (mul_msb) begin
                        case (r_prod) inside
                            P_SX_SX: r_state <= S_DCHK;
                            P_SX_SY, P_SX_SXY: r_state <= S_NEG;
                            default: begin
                                r_prod  <= r_prod + 3'd1;
                                r_state <= S_LOAD;
                            end
                        endcase
                    end else begin
                        r_step <= r_step + STEP_W'(1);
                    end
                end
                // Zero denominator: skip both divisions.
                S_DCHK: begin
                    if (r_acc == '0) begin
                        r_degen <= 1'b1;
                        r_state <= S_EMIT;
                    end else begin
                        r_prod  <= P_N_SXY;
                        r_state <= S_LOAD;
                    end
                end
                S_NEG: begin
                    r_neg   <= r_acc[AW-1];
                    r_step  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_step == STEP_W'(NUM_W - 1)) begin
                        r_state <= S_ROUND;
                    end else begin
                        r_step <= r_step + STEP_W'(1);
                    end
                end
                S_ROUND: begin
                    r_state <= S_CLAMP;
                end
                S_CLAMP: begin
                    r_sat <= r_sat | clamp_sat;
                    if (!r_phase) begin
                        r_phase <= 1'b1;
                        r_prod  <= P_SY_SXX;
                        r_state <= S_LOAD;
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (emit_fire) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Datapath registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            // Pick operands for the next product; n is unsigned, so pad it
            // with zeros rather than its top bit.
            S_LOAD: begin
                case (r_prod)
                    P_N_SXX: begin
                        r_mcand  <= {{(AW - AXX_W){sum_xx[AXX_W-1]}}, sum_xx};
                        r_mplier <= {{(MW - CNT_W){1'b0}}, acc_count};
                    end
                    P_SX_SX: begin
                        r_mcand  <= {{(AW - AX_W){sum_x[AX_W-1]}}, sum_x};
                        r_mplier <= sum_x;
                    end
                    P_N_SXY: begin
                        r_mcand  <= {{(AW - AXX_W){sum_xy[AXX_W-1]}}, sum_xy};
                        r_mplier <= {{(MW - CNT_W){1'b0}}, acc_count};
                    end
                    P_SX_SY: begin
                        r_mcand  <= {{(AW - AX_W){sum_y[AX_W-1]}}, sum_y};
                        r_mplier <= sum_x;
                    end
                    P_SY_SXX: begin
                        r_mcand  <= {{(AW - AXX_W){sum_xx[AXX_W-1]}}, sum_xx};
                        r_mplier <= sum_y;
                    end
                    default: begin
                        r_mcand  <= {{(AW - AXX_W){sum_xy[AXX_W-1]}}, sum_xy};
                        r_mplier <= sum_x;
                    end
                endcase
                if (!prod_neg) begin
                    r_acc <= '0;
                end
            end
            // One shift-add step per multiplier bit.
            S_MUL: begin
                if (r_mplier[0]) begin
                    r_acc <= alu_res;
                end
                r_mcand  <= r_mcand << 1;
                r_mplier <= r_mplier >> 1;
            end
            S_DCHK: begin
                r_den <= r_acc[PW-1:0];
            end
            // Scale the numerator magnitude into Q16.16 quotient position.
            S_NEG: begin
                if (!r_phase) begin
                    r_num <= {mag[PW-1:0], {SLOPE_SHIFT{1'b0}}};
                end else begin
                    r_num <= {{(SLOPE_SHIFT - ICPT_SHIFT){1'b0}}, mag[PW-1:0],
                              {ICPT_SHIFT{1'b0}}};
                end
                r_rem <= '0;
                r_q   <= '0;
            end
            // Restoring division, one quotient bit per cycle.
            S_DIV: begin
                r_rem <= alu_ge ? alu_res[PW-1:0] : div_trial[PW-1:0];
                r_num <= r_num << 1;
                r_q   <= q_step;
            end
            // Round half away from zero: bump when twice the remainder
            // reaches the divisor.
            S_ROUND: begin
                if (alu_ge) begin
                    r_q <= r_q + Q_W'(1);
                end
            end
            S_CLAMP: begin
                if (!r_phase) begin
                    r_slope <= clamp_val;
                end else begin
                    r_icpt <= clamp_val;
                end
            end
            S_EMIT: begin
                if (emit_fire) begin
                    r_out_slope <= r_degen ? '0 : r_slope;
                    r_out_icpt  <= r_degen ? '0 : r_icpt;
                    r_out_min_x <= acc_min_x;
                    r_out_max_x <= acc_max_x;
                    r_out_count <= CNT_OUT_W'(acc_count);
                    if (r_degen) begin
                        r_out_status <= ST_DEGEN;
                    end else if (r_sat || acc_stat.ovf) begin
                        r_out_status <= ST_SAT;
                    end else begin
                        r_out_status <= ST_OK;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Result channel
    // ---------------------------------------------------------------
    assign o_valid        = r_out_valid;
    assign o_slope        = r_out_slope;
    assign o_intercept    = r_out_icpt;
    assign o_min_x        = r_out_min_x;
    assign o_max_x        = r_out_max_x;
    assign o_sample_count = r_out_count;
    assign o_status       = r_out_status;

endmodule

`default_nettype wire

### rtl/core/lrf_chk.sv
// Port-level checks of the linear regression fit block, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none

module lrf_chk
    import lrf_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_valid,
    input wire logic               o_stall,
    input wire logic               i_last,
    input wire logic               o_valid,
    input wire logic               i_stall,
    input wire logic signed [31:0] o_slope,
    input wire logic signed [31:0] o_intercept,
    input wire logic signed [15:0] o_min_x,
    input wire logic signed [15:0] o_max_x,
    input wire logic [1:0]         o_status
);

    // A stalled result beat stays valid, with slope and status unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_slope) && $stable(o_status))
        else $error("result beat changed while stalled");

    // A final sample that is taken raises the input stall right after it.
    a_last_locks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_last |=> o_stall)
        else $error("input open right after a final sample");

    // A degenerate set reports a zero line.
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_DEGEN) |-> (o_slope == '0) && (o_intercept == '0))
        else $error("degenerate result with nonzero slope or intercept");

    // Every set holds at least one sample, so the x range is ordered.
    a_range_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_min_x <= o_max_x)
        else $error("min_x above max_x");

endmodule

bind linear_regression_fit lrf_chk u_lrf_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .i_last      (i_last),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_slope     (o_slope),
    .o_intercept (o_intercept),
    .o_min_x     (o_min_x),
    .o_max_x     (o_max_x),
    .o_status    (o_status)
);

`default_nettype wire
